/* sv/dqqd_pkg.sv */
// Shared types, codes and helper functions for the dual queue QoS dispatcher.
`default_nettype none

package dqqd_pkg;

  // Item function codes.
  typedef enum logic [0:0] {
    FUNC_SUBMIT = 1'b0,
    FUNC_DRAIN  = 1'b1
  } func_t;

  // Result kind codes.
  typedef enum logic [1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_JOB    = 2'd1,
    KIND_IDLE   = 2'd2
  } kind_t;

  // Queue identifiers.
  typedef enum logic [0:0] {
    Q_STREAM = 1'b0,
    Q_BATCH  = 1'b1
  } queue_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_QOS_MODE   = 1'b0,
    REG_BUDGET_PCT = 1'b1
  } reg_idx_t;

  // Back-end sequencer states.
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } st_t;

  localparam logic [6:0] BUDGET_RESET  = 7'd50;
  localparam logic [6:0] BUDGET_MIN    = 7'd1;
  localparam logic [6:0] BUDGET_MAX    = 7'd100;
  localparam logic [6:0] BUDGET_HI     = 7'd75;
  localparam logic [6:0] BUDGET_MID    = 7'd50;
  localparam logic [6:0] BUDGET_LO     = 7'd25;
  localparam logic [2:0] LAT_BASE_LAT  = 3'd2;
  localparam logic [2:0] LAT_BASE_THRU = 3'd6;
  localparam logic [5:0] LAT_SAT       = 6'd63;
  // Reciprocal of ten in Q11, exact for numerators below 100.
  localparam logic [7:0] RECIP_TEN_Q11 = 8'd205;

  // One command as handed from the front end to the back end.
  typedef struct packed {
    func_t              func;
    logic [7:0]         model;
    logic signed [31:0] value;
    logic [31:0]        seed;
  } cmd_t;

  // One stored job.
  typedef struct packed {
    logic [7:0]  model;
    logic [31:0] value;
    logic [31:0] seed;
  } entry_t;

  // One result item.
  typedef struct packed {
    kind_t              kind;
    logic               accepted;
    logic [5:0]         latency;
    logic [7:0]         model;
    logic signed [31:0] value;
    logic [31:0]        seed;
    queue_t             from_queue;
    logic [5:0]         total;
    logic [5:0]         peak;
    logic [31:0]        submitted;
    logic [31:0]        dropped;
    logic               last;
  } res_t;

  // Jobs popped per drain: 1 to 4 from the budget, one more in throughput mode.
  function automatic logic [2:0] jobs_per_drain(input logic [6:0] budget, input logic qos);
    logic [2:0] j;
    begin
      if (budget >= BUDGET_HI) begin
        j = 3'd4;
      end else if (budget >= BUDGET_MID) begin
        j = 3'd3;
      end else if (budget >= BUDGET_LO) begin
        j = 3'd2;
      end else begin
        j = 3'd1;
      end
      jobs_per_drain = j + {2'b00, qos};
    end
  endfunction

  // Budget penalty (100 - budget) / 10, done as a multiply by a reciprocal.
  function automatic logic [3:0] budget_cost(input logic [6:0] budget);
    logic [6:0]  x;
    logic [14:0] p;
    begin
      x = BUDGET_MAX - budget;
      p = 15'(x) * 15'(RECIP_TEN_Q11);
      budget_cost = p[14:11];
    end
  endfunction

endpackage

`default_nettype wire

/* sv/dqqd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module dqqd_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/dqqd_front.sv */
// Front end: accepts items, mixes the seed and buffers commands in a two-entry queue.
`default_nettype none

module dqqd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [7:0]         in_model_tag,
  input  wire logic signed [31:0] in_job_value,
  input  wire logic [31:0]        in_seed,
  input  wire logic [31:0]        in_now_ticks,
  output logic                    cmd_valid,
  input  wire logic               cmd_ready,
  output dqqd_pkg::cmd_t          cmd
);

  import dqqd_pkg::*;

  cmd_t       buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  cmd_t       cmd_in;

  // Classify the incoming item and mix the seed with the time stamp.
  always_comb begin
    cmd_in.func  = func_t'(in_func);
    cmd_in.model = in_model_tag;
    cmd_in.value = in_job_value;
    cmd_in.seed  = in_seed ^ in_now_ticks;
  end

  assign in_ready  = (count_r != 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = buf_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

/* sv/dqqd_back.sv */
// Back end: runs submits and drains against the two ring queues and holds the result register.
`default_nettype none

module dqqd_back #(
  parameter int QUEUE_SLOTS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           mode,
  input  wire logic [6:0]     budget,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire dqqd_pkg::cmd_t cmd,
  output logic                res_valid,
  input  wire logic           res_ready,
  output dqqd_pkg::res_t      res
);

  import dqqd_pkg::*;

  localparam int PW  = $clog2(QUEUE_SLOTS);
  localparam int LSW = PW + 5;
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_SLOTS - 1);

  st_t           state_r, state_nxt;
  logic [PW-1:0] sh_r, sh_nxt, st_r, st_nxt;
  logic [PW-1:0] bh_r, bh_nxt, bt_r, bt_nxt;
  logic [PW-1:0] total_r, total_nxt;
  logic [PW-1:0] peak_r, peak_nxt;
  logic [31:0]   sub_r, sub_nxt;
  logic [31:0]   drop_r, drop_nxt;
  logic [2:0]    remain_r, remain_nxt;
  queue_t        rq_r, rq_nxt;
  logic          res_valid_r, res_valid_nxt;
  res_t          res_r, res_nxt;
  logic          res_load;

  logic          we_s, we_b, re_s, re_b;
  logic [PW-1:0] raddr, waddr;
  entry_t        wentry;
  logic [$bits(entry_t)-1:0] rdata_s, rdata_b;
  entry_t        rentry;

  logic          stream_ne, batch_ne, any_ne, sel_batch, out_free, do_issue;
  logic [PW-1:0] tail_cur, head_cur, tail_inc, depth_new;
  logic [LSW-1:0] lat_sum;
  logic [31:0]   total_w, peak_w;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    begin
      ptr_inc = (p == LAST_SLOT) ? '0 : p + PW'(1);
    end
  endfunction

  function automatic logic [PW:0] ring_depth(input logic [PW-1:0] h, input logic [PW-1:0] t);
    begin
      ring_depth = (t >= h) ? {1'b0, t - h} : (PW+1)'(QUEUE_SLOTS) - {1'b0, h} + {1'b0, t};
    end
  endfunction

  // Queue occupancy and drain source selection.
  assign stream_ne = (sh_r != st_r);
  assign batch_ne  = (bh_r != bt_r);
  assign any_ne    = stream_ne || batch_ne;
  assign sel_batch = mode ? batch_ne : !stream_ne;
  assign out_free  = !res_valid_r || res_ready;
  assign raddr     = sel_batch ? bh_r : sh_r;
  assign rentry    = (rq_r == Q_BATCH) ? entry_t'(rdata_b) : entry_t'(rdata_s);

  // Submit target and latency estimate.
  assign tail_cur  = mode ? bt_r : st_r;
  assign head_cur  = mode ? bh_r : sh_r;
  assign tail_inc  = ptr_inc(tail_cur);
  assign waddr     = tail_cur;
  assign depth_new = total_r + PW'(1);
  assign lat_sum   = LSW'(mode ? LAT_BASE_THRU : LAT_BASE_LAT)
                   + LSW'(budget_cost(budget))
                   + LSW'(depth_new >> 1);

  always_comb begin
    wentry.model = cmd.model;
    wentry.value = cmd.value;
    wentry.seed  = cmd.seed;
  end

  // Sequencer: next state, queue pointers, tallies and the result to load.
  always_comb begin
    state_nxt  = state_r;
    sh_nxt     = sh_r;
    st_nxt     = st_r;
    bh_nxt     = bh_r;
    bt_nxt     = bt_r;
    total_nxt  = total_r;
    peak_nxt   = peak_r;
    sub_nxt    = sub_r;
    drop_nxt   = drop_r;
    remain_nxt = remain_r;
    rq_nxt     = rq_r;
    cmd_ready  = 1'b0;
    we_s       = 1'b0;
    we_b       = 1'b0;
    re_s       = 1'b0;
    re_b       = 1'b0;
    do_issue   = 1'b0;
    res_load   = 1'b0;
    res_nxt    = '0;
    res_nxt.kind       = KIND_SUBMIT;
    res_nxt.from_queue = Q_STREAM;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.func == FUNC_SUBMIT) begin
            if (out_free) begin
              cmd_ready = 1'b1;
              res_load  = 1'b1;
              res_nxt.kind = KIND_SUBMIT;
              res_nxt.last = 1'b1;
              if (total_r >= LAST_SLOT) begin
                // Refused on total depth: only the drop tally moves.
                drop_nxt = drop_r + 32'd1;
              end else begin
                sub_nxt = sub_r + 32'd1;
                if (tail_inc == head_cur) begin
                  // Refused on a full queue.
                  drop_nxt = drop_r + 32'd1;
                end else begin
                  we_s      = !mode;
                  we_b      = mode;
                  total_nxt = depth_new;
                  if (mode) begin
                    bt_nxt = tail_inc;
                  end else begin
                    st_nxt = tail_inc;
                  end
                  if (depth_new > peak_r) begin
                    peak_nxt = depth_new;
                  end
                  res_nxt.accepted = 1'b1;
                  res_nxt.latency  = (lat_sum > LSW'(LAT_SAT)) ? LAT_SAT : lat_sum[5:0];
                end
              end
            end
          end else begin
            if (!any_ne) begin
              // Nothing held: one idle result.
              if (out_free) begin
                cmd_ready    = 1'b1;
                res_load     = 1'b1;
                res_nxt.kind = KIND_IDLE;
                res_nxt.last = 1'b1;
              end
            end else begin
              cmd_ready  = 1'b1;
              do_issue   = 1'b1;
              remain_nxt = jobs_per_drain(budget, mode);
              state_nxt  = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          res_load           = 1'b1;
          res_nxt.kind       = KIND_JOB;
          res_nxt.model      = rentry.model;
          res_nxt.value      = $signed(rentry.value);
          res_nxt.seed       = rentry.seed;
          res_nxt.from_queue = rq_r;
          res_nxt.last       = (remain_r == 3'd1) || !any_ne;
          remain_nxt         = remain_r - 3'd1;
          if ((remain_r == 3'd1) || !any_ne) begin
            state_nxt = ST_IDLE;
          end else begin
            do_issue = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Common result fields give the state after this result; the pop of the
    // next job, started below, is not yet counted in them.
    total_w           = 32'(total_nxt);
    peak_w            = 32'(peak_nxt);
    res_nxt.total     = total_w[5:0];
    res_nxt.peak      = peak_w[5:0];
    res_nxt.submitted = sub_nxt;
    res_nxt.dropped   = drop_nxt;

    // Pop one job: read its entry and advance the head.
    if (do_issue) begin
      rq_nxt    = queue_t'(sel_batch);
      total_nxt = total_r - PW'(1);
      if (sel_batch) begin
        re_b   = 1'b1;
        bh_nxt = ptr_inc(bh_r);
      end else begin
        re_s   = 1'b1;
        sh_nxt = ptr_inc(sh_r);
      end
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r && !res_ready;
    if (res_load) begin
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sh_r        <= '0;
      st_r        <= '0;
      bh_r        <= '0;
      bt_r        <= '0;
      total_r     <= '0;
      peak_r      <= '0;
      sub_r       <= '0;
      drop_r      <= '0;
      remain_r    <= '0;
      rq_r        <= Q_STREAM;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sh_r        <= sh_nxt;
      st_r        <= st_nxt;
      bh_r        <= bh_nxt;
      bt_r        <= bt_nxt;
      total_r     <= total_nxt;
      peak_r      <= peak_nxt;
      sub_r       <= sub_nxt;
      drop_r      <= drop_nxt;
      remain_r    <= remain_nxt;
      rq_r        <= rq_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // Job stores for the two queues.
  dqqd_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_SLOTS)
  ) u_stream_ram (
    .clk  (clk),
    .we   (we_s),
    .waddr(waddr),
    .wdata(wentry),
    .re   (re_s),
    .raddr(raddr),
    .rdata(rdata_s)
  );

  dqqd_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_SLOTS)
  ) u_batch_ram (
    .clk  (clk),
    .we   (we_b),
    .waddr(waddr),
    .wdata(wentry),
    .re   (re_b),
    .raddr(raddr),
    .rdata(rdata_b)
  );

  // The running total always equals the sum of the two ring depths.
  a_total_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (PW+2)'(total_r) == (PW+2)'(ring_depth(sh_r, st_r)) + (PW+2)'(ring_depth(bh_r, bt_r)))
    else $error("total depth out of step with ring pointers");

  // The total never passes the admission limit.
  a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= LAST_SLOT)
    else $error("total depth above admission limit");

  // A pop is only issued against a queue that holds a job.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_issue |-> (sel_batch ? batch_ne : stream_ne))
    else $error("pop issued on an empty queue");

  // Stores are never written while a drain reads them.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !((we_s || we_b) && (re_s || re_b)))
    else $error("queue write during a drain read");

  // While emitting, at least one job of the budget is left.
  a_emit_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (remain_r != 3'd0))
    else $error("emit state with no budget left");

endmodule

`default_nettype wire

/* sv/dual_queue_qos_dispatcher.sv */
// Result path: a submit result passes the front-end queue and the result register; a drain's
// first job also passes a queue store read, and later jobs follow one per cycle while out_ready
// stays high. Flow: the back end completes a submit as it takes it; a drain holds off further
// commands until its last job is loaded, while the front end still buffers up to two items.
// Reset (synchronous, rst_n low): pointers, tallies, peak and handshakes clear, the budget is 50
// and the mode is the latency mode; queue stores are not cleared and only written entries are read.
`default_nettype none

module dual_queue_qos_dispatcher #(
  parameter int QUEUE_SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [6:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [7:0]         in_model_tag,
  input  wire logic signed [31:0] in_job_value,
  input  wire logic [31:0]        in_seed,
  input  wire logic [31:0]        in_now_ticks,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic                    out_accepted,
  output logic [5:0]              out_latency_estimate,
  output logic [7:0]              out_out_model,
  output logic signed [31:0]      out_out_value,
  output logic [31:0]             out_out_seed,
  output logic                    out_from_queue,
  output logic [5:0]              out_total_depth,
  output logic [5:0]              out_peak_depth,
  output logic [31:0]             out_submitted_count,
  output logic [31:0]             out_dropped_count,
  output logic                    out_last
);

  import dqqd_pkg::*;

  logic       mode_r, mode_nxt;
  logic [6:0] budget_r, budget_nxt;
  logic       cfg_write;
  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;
  res_t       res;

  // Configuration registers; an out-of-range budget is ignored.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    mode_nxt   = mode_r;
    budget_nxt = budget_r;
    if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_QOS_MODE: begin
          mode_nxt = cfg_wdata[0];
        end
        REG_BUDGET_PCT: begin
          if ((cfg_wdata >= BUDGET_MIN) && (cfg_wdata <= BUDGET_MAX)) begin
            budget_nxt = cfg_wdata;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      budget_r <= BUDGET_RESET;
    end else begin
      mode_r   <= mode_nxt;
      budget_r <= budget_nxt;
    end
  end

  dqqd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_model_tag(in_model_tag),
    .in_job_value(in_job_value),
    .in_seed     (in_seed),
    .in_now_ticks(in_now_ticks),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  dqqd_back #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .budget   (budget_r),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(out_valid),
    .res_ready(out_ready),
    .res      (res)
  );

  // Result fields onto the output ports.
  assign out_kind             = res.kind;
  assign out_accepted         = res.accepted;
  assign out_latency_estimate = res.latency;
  assign out_out_model        = res.model;
  assign out_out_value        = res.value;
  assign out_out_seed         = res.seed;
  assign out_from_queue       = res.from_queue;
  assign out_total_depth      = res.total;
  assign out_peak_depth       = res.peak;
  assign out_submitted_count  = res.submitted;
  assign out_dropped_count    = res.dropped;
  assign out_last             = res.last;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the dual queue QoS dispatcher: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import dqqd_pkg::*;

  localparam int SLOTS = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int NUM_PHASES = 8;
  // Budget setting of each random phase, phase 0 in the lowest slot.
  localparam logic [7:0][6:0] PHASE_BUDGET =
    {7'd49, 7'd74, 7'd25, 7'd50, 7'd75, 7'd24, 7'd100, 7'd1};

  // One input transfer.
  typedef struct packed {
    func_t              func;
    logic [7:0]         model;
    logic signed [31:0] value;
    logic [31:0]        seed;
    logic [31:0]        now;
  } job_item_t;

  // One row of the directed table: a register write or an item, with an optional typed reply.
  typedef struct packed {
    logic       is_cfg;
    reg_idx_t   reg_idx;
    logic [6:0] wdata;
    logic       typed;
    job_item_t  item;
    res_t       want;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = 1'b0;
  logic [6:0]              cfg_wdata = 7'd0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_func = 1'b0;
  logic [7:0]              in_model_tag = 8'd0;
  logic signed [31:0]      in_job_value = 32'sd0;
  logic [31:0]             in_seed = 32'd0;
  logic [31:0]             in_now_ticks = 32'd0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_kind;
  logic                    out_accepted;
  logic [5:0]              out_latency_estimate;
  logic [7:0]              out_out_model;
  logic signed [31:0]      out_out_value;
  logic [31:0]             out_out_seed;
  logic                    out_from_queue;
  logic [5:0]              out_total_depth;
  logic [5:0]              out_peak_depth;
  logic [31:0]             out_submitted_count;
  logic [31:0]             out_dropped_count;
  logic                    out_last;

  // Predicted dispatcher state.
  entry_t     job_ring [2][SLOTS];
  logic [5:0] ring_head [2];
  logic [5:0] ring_tail [2];
  logic [6:0] peak_jobs;
  logic [31:0] submit_tally;
  logic [31:0] drop_tally;
  logic       mode_m;
  logic [6:0] budget_m;

  res_t pending_results [$];
  res_t got_r;
  res_t want_r;
  int   mismatches = 0;
  int   result_idx = 0;
  int   ready_left = 0;
  logic calm = 1'b0;

  dual_queue_qos_dispatcher i_dut (.*);

  always #10 clk = ~clk;

  // Jobs held in both rings together.
  function automatic logic [6:0] held_jobs();
    logic [5:0] in_stream;
    logic [5:0] in_batch;
    in_stream = ring_tail[Q_STREAM] - ring_head[Q_STREAM];
    in_batch = ring_tail[Q_BATCH] - ring_head[Q_BATCH];
    return {1'b0, in_stream} + {1'b0, in_batch};
  endfunction

  // Stamps the depth, peak and tallies as they stand after this result.
  function automatic res_t with_tallies(input res_t r);
    logic [6:0] held;
    held = held_jobs();
    r.total = held[5:0];
    r.peak = peak_jobs[5:0];
    r.submitted = submit_tally;
    r.dropped = drop_tally;
    return r;
  endfunction

  // Works out the results of one accepted item and queues them in order.
  task automatic predict_dispatch(input job_item_t it);
    res_t       r;
    entry_t     e;
    queue_t     pref;
    queue_t     q;
    logic [5:0] tail_after;
    logic [6:0] held;
    int         lat;
    int         budget;
    int         n_jobs;
    int         i;
    pref = queue_t'(mode_m);
    if (it.func == FUNC_SUBMIT) begin
      r = '0;
      r.kind = KIND_SUBMIT;
      r.last = 1'b1;
      tail_after = ring_tail[pref] + 6'd1;
      if (held_jobs() >= 7'(SLOTS - 1)) begin
        // Refused on total depth: counted as dropped only.
        drop_tally++;
      end else begin
        submit_tally++;
        if (tail_after == ring_head[pref]) begin
          drop_tally++;
        end else begin
          e.model = it.model;
          e.value = it.value;
          e.seed = it.seed ^ it.now;
          job_ring[pref][ring_tail[pref]] = e;
          ring_tail[pref] = tail_after;
          held = held_jobs();
          if (held > peak_jobs) begin
            peak_jobs = held;
          end
          lat = (mode_m ? int'(LAT_BASE_THRU) : int'(LAT_BASE_LAT))
              + (int'(BUDGET_MAX) - int'(budget_m)) / 10 + int'(held) / 2;
          if (lat > int'(LAT_SAT)) begin
            lat = int'(LAT_SAT);
          end
          r.accepted = 1'b1;
          r.latency = 6'(lat);
        end
      end
      pending_results.push_back(with_tallies(r));
    end else begin
      // A drain pops up to its budget, preferred ring first, then the other one.
      budget = (budget_m >= BUDGET_HI) ? 4 : (budget_m >= BUDGET_MID) ? 3 :
               (budget_m >= BUDGET_LO) ? 2 : 1;
      budget += int'(mode_m);
      held = held_jobs();
      n_jobs = (int'(held) < budget) ? int'(held) : budget;
      if (n_jobs == 0) begin
        r = '0;
        r.kind = KIND_IDLE;
        r.last = 1'b1;
        pending_results.push_back(with_tallies(r));
      end
      for (i = 0; i < n_jobs; i++) begin
        q = (ring_head[pref] != ring_tail[pref]) ? pref : queue_t'(!mode_m);
        e = job_ring[q][ring_head[q]];
        ring_head[q] = ring_head[q] + 6'd1;
        r = '0;
        r.kind = KIND_JOB;
        r.model = e.model;
        r.value = e.value;
        r.seed = e.seed;
        r.from_queue = q;
        r.last = (i == n_jobs - 1);
        pending_results.push_back(with_tallies(r));
      end
    end
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write, only issued with the block idle.
  task automatic write_reg(input reg_idx_t idx, input logic [6:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_QOS_MODE) begin
      mode_m = data[0];
    end else if (data >= BUDGET_MIN && data <= BUDGET_MAX) begin
      budget_m = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends one item, with an optional idle burst first, and predicts it on transfer.
  task automatic push_item(input job_item_t it);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= it.func;
    in_model_tag <= it.model;
    in_job_value <= it.value;
    in_seed <= it.seed;
    in_now_ticks <= it.now;
    do @(posedge clk); while (!in_ready);
    predict_dispatch(it);
  endtask

  function automatic stim_row_t job_row(input func_t f, input logic [7:0] m,
                                        input logic [31:0] v, input logic [31:0] s,
                                        input logic [31:0] n);
    stim_row_t row;
    row = '0;
    row.item.func = f;
    row.item.model = m;
    row.item.value = v;
    row.item.seed = s;
    row.item.now = n;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input reg_idx_t idx, input logic [6:0] d);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.wdata = d;
    return row;
  endfunction

  // Attaches a typed single reply (submit or idle) to an item row.
  function automatic stim_row_t reply_row(input stim_row_t row, input kind_t k,
                                          input logic acc, input logic [5:0] lat,
                                          input logic [5:0] depth, input logic [5:0] peak,
                                          input logic [31:0] sub, input logic [31:0] drop);
    row.typed = 1'b1;
    row.want = '0;
    row.want.kind = k;
    row.want.accepted = acc;
    row.want.latency = lat;
    row.want.total = depth;
    row.want.peak = peak;
    row.want.submitted = sub;
    row.want.dropped = drop;
    row.want.last = 1'b1;
    return row;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf({"kind=%0d acc=%0d lat=%0d model=%02h value=%08h seed=%08h q=%0d",
                      " depth=%0d peak=%0d sub=%0d drop=%0d last=%0d"},
                     r.kind, r.accepted, r.latency, r.model, r.value, r.seed, r.from_queue,
                     r.total, r.peak, r.submitted, r.dropped, r.last);
  endfunction

  // Result side stalls in random bursts, and stays ready in the calm tail of the run.
  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left = ready_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready <= 1'b0;
      ready_left = $urandom_range(1, 16) - 1;
    end else begin
      out_ready <= 1'b1;
      ready_left = $urandom_range(1, 24) - 1;
    end
  end

  // Each result transfer is checked field by field against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_r.kind = kind_t'(out_kind);
      got_r.accepted = out_accepted;
      got_r.latency = out_latency_estimate;
      got_r.model = out_out_model;
      got_r.value = out_out_value;
      got_r.seed = out_out_seed;
      got_r.from_queue = queue_t'(out_from_queue);
      got_r.total = out_total_depth;
      got_r.peak = out_peak_depth;
      got_r.submitted = out_submitted_count;
      got_r.dropped = out_dropped_count;
      got_r.last = out_last;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result %0d arrived with nothing expected: %s", result_idx, show(got_r));
        end
      end else begin
        want_r = pending_results.pop_front();
        if (got_r.kind != want_r.kind || got_r.accepted != want_r.accepted ||
            got_r.latency != want_r.latency || got_r.model != want_r.model ||
            got_r.value != want_r.value || got_r.seed != want_r.seed ||
            got_r.from_queue != want_r.from_queue || got_r.total != want_r.total ||
            got_r.peak != want_r.peak || got_r.submitted != want_r.submitted ||
            got_r.dropped != want_r.dropped || got_r.last != want_r.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result %0d differs", result_idx);
            $display("  expected %s", show(want_r));
            $display("  actual   %s", show(got_r));
          end
        end
      end
      result_idx++;
    end
  end

  // Stimulus: reset, directed table, random phases, then the final verdict.
  initial begin
    stim_row_t rows [$];
    job_item_t it;
    int        k;
    int        p;
    int        submit_pct;
    int        n_items;

    ring_head = '{6'd0, 6'd0};
    ring_tail = '{6'd0, 6'd0};
    peak_jobs = 7'd0;
    submit_tally = 32'd0;
    drop_tally = 32'd0;
    mode_m = 1'b0;
    budget_m = BUDGET_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Right after reset: an empty drain with junk in its fields, then replies at budget 50.
    rows.push_back(reply_row(job_row(FUNC_DRAIN, 8'hFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
                                     32'hFFFFFFFF), KIND_IDLE, 1'b0, 6'd0, 6'd0, 6'd0, 0, 0));
    rows.push_back(reply_row(job_row(FUNC_SUBMIT, 8'h00, 32'h80000000, 32'hFFFFFFFF,
                                     32'h00000000), KIND_SUBMIT, 1'b1, 6'd7, 6'd1, 6'd1, 1, 0));
    rows.push_back(reply_row(job_row(FUNC_SUBMIT, 8'hFF, 32'h7FFFFFFF, 32'h00000000,
                                     32'hFFFFFFFF), KIND_SUBMIT, 1'b1, 6'd8, 6'd2, 6'd2, 2, 0));
    rows.push_back(job_row(FUNC_SUBMIT, 8'h5A, 32'hFFFFFFFF, 32'hA5A5A5A5, 32'h5A5A5A5A));
    // Throughput mode: submits go to batch, and a drain serves batch before stream.
    rows.push_back(reg_row(REG_QOS_MODE, 7'h01));
    rows.push_back(job_row(FUNC_SUBMIT, 8'h01, 32'h00000000, 32'h12345678, 32'h87654321));
    rows.push_back(job_row(FUNC_SUBMIT, 8'h80, 32'h00000001, 32'hDEADBEEF, 32'h00000000));
    rows.push_back(job_row(FUNC_DRAIN, 8'h00, 32'h0, 32'h0, 32'h0));
    rows.push_back(job_row(FUNC_DRAIN, 8'h00, 32'h0, 32'h0, 32'h0));
    rows.push_back(job_row(FUNC_DRAIN, 8'hAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555));
    // A budget of 100 is taken, out-of-range budget writes leave the register alone; mode takes bit 0 only.
    rows.push_back(reg_row(REG_BUDGET_PCT, 7'd100));
    rows.push_back(reg_row(REG_BUDGET_PCT, 7'd0));
    rows.push_back(reg_row(REG_BUDGET_PCT, 7'd101));
    rows.push_back(reg_row(REG_BUDGET_PCT, 7'd127));
    rows.push_back(reg_row(REG_QOS_MODE, 7'h7E));
    for (k = 0; k < 6; k++) begin
      rows.push_back(job_row(FUNC_SUBMIT, 8'(8'h10 << k), 32'(-k), 32'(k * 32'h1111_1111),
                             32'(32'h8000_0000 >> k)));
    end
    rows.push_back(job_row(FUNC_DRAIN, 8'h00, 32'h0, 32'h0, 32'h0));
    rows.push_back(job_row(FUNC_DRAIN, 8'h00, 32'h0, 32'h0, 32'h0));
    // Smallest budget, with jobs spread over both rings across a mode change.
    rows.push_back(reg_row(REG_BUDGET_PCT, 7'd1));
    rows.push_back(job_row(FUNC_SUBMIT, 8'h11, 32'h00000010, 32'hFFFF0000, 32'h0000FFFF));
    rows.push_back(job_row(FUNC_SUBMIT, 8'h22, 32'hFFFFFFF0, 32'h0F0F0F0F, 32'hF0F0F0F0));
    rows.push_back(reg_row(REG_QOS_MODE, 7'h01));
    rows.push_back(job_row(FUNC_SUBMIT, 8'h33, 32'h40000000, 32'h00000001, 32'h80000000));
    rows.push_back(job_row(FUNC_DRAIN, 8'h00, 32'h0, 32'h0, 32'h0));
    rows.push_back(job_row(FUNC_DRAIN, 8'h00, 32'h0, 32'h0, 32'h0));
    // Budget thresholds seen through the latency penalty and the drain size.
    rows.push_back(reg_row(REG_BUDGET_PCT, 7'd24));
    rows.push_back(job_row(FUNC_SUBMIT, 8'h44, 32'h00000044, 32'h44444444, 32'h00000000));
    rows.push_back(reg_row(REG_BUDGET_PCT, 7'd25));
    rows.push_back(job_row(FUNC_SUBMIT, 8'h55, 32'h00000055, 32'h55555555, 32'h00000000));
    rows.push_back(reg_row(REG_BUDGET_PCT, 7'd74));
    rows.push_back(job_row(FUNC_SUBMIT, 8'h66, 32'h00000066, 32'h66666666, 32'h00000000));
    rows.push_back(reg_row(REG_BUDGET_PCT, 7'd75));
    rows.push_back(job_row(FUNC_DRAIN, 8'h00, 32'h0, 32'h0, 32'h0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].reg_idx, rows[i].wdata);
      end else begin
        push_item(rows[i].item);
        if (rows[i].typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back(rows[i].want);
        end
      end
    end

    // Random phases: fill to the depth limit, mixed traffic, or mostly drains.
    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_QOS_MODE, {6'($urandom), p[0]});
      if (p == 6) begin
        write_reg(REG_BUDGET_PCT, 7'($urandom));
      end
      write_reg(REG_BUDGET_PCT, PHASE_BUDGET[p]);
      calm = (p == NUM_PHASES - 1);
      case (p % 3)
        0: begin
          submit_pct = 90;
          n_items = 70;
        end
        1: begin
          submit_pct = 50;
          n_items = 20;
        end
        default: begin
          submit_pct = 15;
          n_items = 20;
        end
      endcase
      for (k = 0; k < n_items; k++) begin
        if (p == 1 && k == 10) begin
          wait_drained();
        end
        it.func = ($urandom_range(0, 99) < submit_pct) ? FUNC_SUBMIT : FUNC_DRAIN;
        it.model = 8'($urandom);
        it.value = 32'($urandom);
        it.seed = 32'($urandom);
        it.now = 32'($urandom);
        push_item(it);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("dual_queue_qos_dispatcher: match");
    end else begin
      $display("dual_queue_qos_dispatcher: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake or missing results.
  initial begin
    #5_000_000;
    $display("dual_queue_qos_dispatcher: mismatch");
    $finish;
  end

endmodule
